// ----- rtl/core/gsod_pkg.sv -----
// Package of shared types, constants and register codes of the sigma outlier detector.
`timescale 1ns / 1ps
`default_nettype none

package gsod_pkg;

  localparam int COORD_BITS     = 12;
  localparam int VALUE_BITS     = 32;
  localparam int SIGMA_BITS     = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam int PROD_BITS      = SIGMA_BITS + VALUE_BITS;
  // Difference of two values is one bit wider; the Q8.8 alignment adds eight more.
  localparam int DIFF_BITS      = VALUE_BITS + 1;
  localparam int SCALED_BITS    = DIFF_BITS + 8;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [SIGMA_BITS-1:0]        sigma_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SIGMA         = CFG_INDEX_BITS'(0),
    REG_SKIP_X        = CFG_INDEX_BITS'(1),
    REG_SKIP_Y        = CFG_INDEX_BITS'(2),
    REG_USE_ABS       = CFG_INDEX_BITS'(3),
    REG_VALUE_BAD     = CFG_INDEX_BITS'(4),
    REG_VALUE_MISSING = CFG_INDEX_BITS'(5),
    REG_STATS_BAD     = CFG_INDEX_BITS'(6),
    REG_STATS_MISSING = CFG_INDEX_BITS'(7)
  } reg_index_t;

  localparam sigma_t SIGMA_RESET   = SIGMA_BITS'(512);
  localparam value_t BAD_RESET     = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam value_t MISSING_RESET = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
  localparam value_t VALUE_MIN     = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam value_t VALUE_MAX     = {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef struct packed {
    sigma_t sigma_scale;
    coord_t skip_x;
    coord_t skip_y;
    logic   use_abs;
    value_t value_bad;
    value_t value_missing;
    value_t stats_bad;
    value_t stats_missing;
  } cfg_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    value_t observed;
    value_t mean_value;
    value_t deviation;
    logic   plane_start;
  } item_t;

  typedef struct packed {
    logic   have_reported;
    coord_t last_col;
    coord_t last_row;
  } track_t;

  typedef struct packed {
    logic   hit;
    value_t value;
    track_t track_next;
  } verdict_t;

endpackage

`default_nettype wire

// ----- rtl/core/gsod_in_if.sv -----
// Stream interface carrying grid point words into the detector.
`timescale 1ns / 1ps
`default_nettype none

interface gsod_in_if;
  logic                valid;
  logic                ready;
  gsod_pkg::coord_t    col;
  gsod_pkg::coord_t    row;
  gsod_pkg::value_t    observed;
  gsod_pkg::value_t    mean_value;
  gsod_pkg::value_t    deviation;
  logic                plane_start;

  modport source (output valid, col, row, observed, mean_value, deviation, plane_start,
                  input ready);
  modport sink   (input valid, col, row, observed, mean_value, deviation, plane_start,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gsod_out_if.sv -----
// Stream interface carrying outlier report words out of the detector.
`timescale 1ns / 1ps
`default_nettype none

interface gsod_out_if;
  logic             valid;
  logic             ready;
  gsod_pkg::coord_t out_col;
  gsod_pkg::coord_t out_row;
  gsod_pkg::value_t out_value;
  gsod_pkg::value_t out_mean;
  gsod_pkg::value_t out_deviation;

  modport source (output valid, out_col, out_row, out_value, out_mean, out_deviation,
                  input ready);
  modport sink   (input valid, out_col, out_row, out_value, out_mean, out_deviation,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gsod_cfg_if.sv -----
// Write channel interface for the detector's configuration registers.
`timescale 1ns / 1ps
`default_nettype none

interface gsod_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [gsod_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [gsod_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/grid_sigma_outlier_detector.sv -----
// Top level of the grid sigma outlier detector: input register, tracking state, result register.
// Path: an accepted word is held and judged in the input register; its report, if any, is
// registered in the result register and presented from there on the result channel.
// Throughput: one grid point per cycle; the single multiply and compare path sets this figure.
// A stalled result channel holds only reporting points; points that report nothing still pass.
// Reset (rst, synchronous, active high) empties both registers, clears the report memory
// and restores every configuration register to its documented value.
`timescale 1ns / 1ps
`default_nettype none

module grid_sigma_outlier_detector (
  input  wire logic clk,
  input  wire logic rst,
  gsod_in_if.sink   samples,
  gsod_out_if.source results,
  gsod_cfg_if.sink  cfg
);

  gsod_pkg::cfg_t     regs;
  gsod_pkg::item_t    stage;
  logic               stage_valid;
  gsod_pkg::track_t   track;
  gsod_pkg::verdict_t verdict;
  logic               advance;
  logic               report;
  logic               out_valid;

  // Configuration registers. Writes are only expected while the pipeline is idle.
  gsod_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // The point in the input register is judged against the current tracking state.
  gsod_eval u_eval (
    .item    (stage),
    .regs    (regs),
    .track   (track),
    .verdict (verdict)
  );

  // A point leaves the input register when it reports nothing, or when the result register is
  // empty or being emptied. This lets the result register act as the skid stage between sides.
  assign advance = stage_valid && (!verdict.hit || !out_valid || results.ready);
  assign report  = advance && verdict.hit;

  assign samples.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (samples.ready) begin
      stage_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      stage.col         <= samples.col;
      stage.row         <= samples.row;
      stage.observed    <= samples.observed;
      stage.mean_value  <= samples.mean_value;
      stage.deviation   <= samples.deviation;
      stage.plane_start <= samples.plane_start;
    end
  end

  // Tracking state moves only as points leave the input register, so each point sees the
  // effect of every earlier one.
  always_ff @(posedge clk) begin
    if (rst) begin
      track <= '0;
    end else if (advance) begin
      track <= verdict.track_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      results.out_col       <= stage.col;
      results.out_row       <= stage.row;
      results.out_value     <= verdict.value;
      results.out_mean      <= stage.mean_value;
      results.out_deviation <= stage.deviation;
    end
  end

  assign results.valid = out_valid;

  // A waiting report is always the last reported point.
  a_out_matches_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (results.out_col == track.last_col) && (results.out_row == track.last_row))
    else $error("pending report does not match the tracked point");

  // Input is only refused while a point occupies the input register.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> stage_valid)
    else $error("input refused with an empty input register");

  // A report always arms suppression.
  a_report_arms: assert property (@(posedge clk) disable iff (rst)
    report |=> track.have_reported)
    else $error("report did not arm suppression");

  // A plane start that reports nothing leaves suppression disarmed.
  a_plane_clears: assert property (@(posedge clk) disable iff (rst)
    advance && stage.plane_start && !verdict.hit |=> !track.have_reported)
    else $error("plane start did not clear suppression");

  // A report is never dropped: a new one is only loaded when the slot is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    report |-> !out_valid || results.ready)
    else $error("pending report overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/gsod_cfg.sv -----
// Configuration register file of the detector.
`timescale 1ns / 1ps
`default_nettype none

module gsod_cfg (
  input  wire logic     clk,
  input  wire logic     rst,
  gsod_cfg_if.sink      cfg,
  output gsod_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sigma_scale     <= gsod_pkg::SIGMA_RESET;
      regs.skip_x          <= '0;
      regs.skip_y          <= '0;
      regs.use_abs         <= 1'b0;
      regs.value_bad       <= gsod_pkg::BAD_RESET;
      regs.value_missing   <= gsod_pkg::MISSING_RESET;
      regs.stats_bad       <= gsod_pkg::BAD_RESET;
      regs.stats_missing   <= gsod_pkg::MISSING_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (gsod_pkg::reg_index_t'(cfg.index))
        gsod_pkg::REG_SIGMA:
          regs.sigma_scale <= cfg.data[gsod_pkg::SIGMA_BITS-1:0];
        gsod_pkg::REG_SKIP_X:        regs.skip_x  <= cfg.data[gsod_pkg::COORD_BITS-1:0];
        gsod_pkg::REG_SKIP_Y:        regs.skip_y  <= cfg.data[gsod_pkg::COORD_BITS-1:0];
        gsod_pkg::REG_USE_ABS:       regs.use_abs <= cfg.data[0];
        gsod_pkg::REG_VALUE_BAD:
          regs.value_bad <= gsod_pkg::value_t'(cfg.data[gsod_pkg::VALUE_BITS-1:0]);
        gsod_pkg::REG_VALUE_MISSING:
          regs.value_missing <= gsod_pkg::value_t'(cfg.data[gsod_pkg::VALUE_BITS-1:0]);
        gsod_pkg::REG_STATS_BAD:
          regs.stats_bad <= gsod_pkg::value_t'(cfg.data[gsod_pkg::VALUE_BITS-1:0]);
        gsod_pkg::REG_STATS_MISSING:
          regs.stats_missing <= gsod_pkg::value_t'(cfg.data[gsod_pkg::VALUE_BITS-1:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gsod_eval.sv -----
// Combinational evaluation of one grid point: suppression, sentinels and sigma test.
`timescale 1ns / 1ps
`default_nettype none

module gsod_eval (
  input  wire gsod_pkg::item_t  item,
  input  wire gsod_pkg::cfg_t   regs,
  input  wire gsod_pkg::track_t track,
  output gsod_pkg::verdict_t    verdict
);

  localparam int OFS_BITS = gsod_pkg::COORD_BITS + 2;

  logic                                 active;
  logic signed [OFS_BITS-1:0]           dx;
  logic signed [OFS_BITS-1:0]           dy;
  logic                                 suppressed;
  logic                                 sentinel;
  gsod_pkg::value_t                     value;
  logic [gsod_pkg::VALUE_BITS-1:0]      dev_mag;
  logic [gsod_pkg::PROD_BITS-1:0]       prod;
  logic signed [gsod_pkg::DIFF_BITS-1:0] diff;
  logic [gsod_pkg::DIFF_BITS-1:0]       diff_mag;
  logic [gsod_pkg::SCALED_BITS-1:0]     scaled;
  logic                                 outlier;

  // A plane start forgets the last report before this point is judged.
  assign active = track.have_reported && !item.plane_start;

  assign dx = $signed({2'b00, item.col}) - $signed({2'b00, track.last_col});
  assign dy = $signed({2'b00, item.row}) - $signed({2'b00, track.last_row});
  assign suppressed = active && (dx < $signed({2'b00, regs.skip_x}))
                             && (dy < $signed({2'b00, regs.skip_y}));

  assign sentinel = (item.observed   == regs.value_bad) || (item.observed   == regs.value_missing)
                 || (item.deviation  == regs.stats_bad) || (item.deviation  == regs.stats_missing)
                 || (item.mean_value == regs.stats_bad) || (item.mean_value == regs.stats_missing);

  // The most negative code has no positive twin and saturates.
  always_comb begin
    value = item.observed;
    if (regs.use_abs && item.observed[gsod_pkg::VALUE_BITS-1]) begin
      if (item.observed == gsod_pkg::VALUE_MIN) begin
        value = gsod_pkg::VALUE_MAX;
      end else begin
        value = -item.observed;
      end
    end
  end

  // Unsigned magnitude, so the most negative deviation gives 2^31 exactly.
  assign dev_mag = item.deviation[gsod_pkg::VALUE_BITS-1]
                 ? (~item.deviation + 1'b1) : item.deviation;
  assign prod = gsod_pkg::PROD_BITS'(regs.sigma_scale) * gsod_pkg::PROD_BITS'(dev_mag);

  assign diff = $signed({value[gsod_pkg::VALUE_BITS-1], value})
              - $signed({item.mean_value[gsod_pkg::VALUE_BITS-1], item.mean_value});
  assign diff_mag = diff[gsod_pkg::DIFF_BITS-1] ? (~diff + 1'b1) : diff;
  assign scaled = {diff_mag, 8'h00};
  assign outlier = gsod_pkg::PROD_BITS'(scaled) > prod;

  always_comb begin
    verdict.hit                      = !suppressed && !sentinel && outlier;
    verdict.value                    = value;
    verdict.track_next.have_reported = active;
    verdict.track_next.last_col      = track.last_col;
    verdict.track_next.last_row      = track.last_row;
    if (verdict.hit) begin
      verdict.track_next.have_reported = 1'b1;
      verdict.track_next.last_col      = item.col;
      verdict.track_next.last_row      = item.row;
    end
  end

endmodule

`default_nettype wire

// ----- sim/grid_sigma_outlier_detector_tb.sv -----
// Self-checking testbench of the grid sigma outlier detector: directed cases, then random raster scans.
`timescale 1ns / 1ps

module grid_sigma_outlier_detector_tb;

  // Clocking and run length.
  localparam int     HALF_PERIOD     = 10;
  localparam int     RESET_CYCLES    = 4;
  // The block holds a word in its input and result registers; a little slack covers words that report nothing.
  localparam int     SETTLE_CYCLES   = 4;
  localparam int     END_WAIT_LIMIT  = 20000;
  localparam longint RUN_LIMIT_NS    = 64'd10_000_000;
  localparam int     SCAN_SEGMENTS   = 8;
  localparam int     SEGMENT_POINTS  = 218;
  // First register index past the documented list.
  localparam int     REG_COUNT       = 8;
  // One unit in Q16.16.
  localparam gsod_pkg::value_t ONE   = 32'sh0001_0000;

  // One expected outlier report, in the field order of the result channel.
  typedef struct {
    gsod_pkg::coord_t col;
    gsod_pkg::coord_t row;
    gsod_pkg::value_t value;
    gsod_pkg::value_t mean;
    gsod_pkg::value_t deviation;
  } outlier_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gsod_in_if  samples_bus ();
  gsod_out_if results_bus ();
  gsod_cfg_if cfg_bus ();

  grid_sigma_outlier_detector DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_bus),
    .results (results_bus),
    .cfg     (cfg_bus)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Our own copy of the configuration registers, updated on every accepted register write.
  gsod_pkg::sigma_t cur_sigma;
  gsod_pkg::coord_t cur_skip_x;
  gsod_pkg::coord_t cur_skip_y;
  logic             cur_use_abs;
  gsod_pkg::value_t cur_value_bad;
  gsod_pkg::value_t cur_value_missing;
  gsod_pkg::value_t cur_stats_bad;
  gsod_pkg::value_t cur_stats_missing;

  // Our own copy of the suppression memory: whether a report has been made in this plane,
  // and where it was.
  logic             tracked_valid;
  gsod_pkg::coord_t tracked_col;
  gsod_pkg::coord_t tracked_row;

  // Reports predicted for accepted grid points, oldest first.
  outlier_t pending_reports [$];

  // Idling percentages of the sender and the receiver, changed from phase to phase.
  int send_idle_pct;
  int recv_stall_pct;

  // Raster cursor of the random scan, relative to a random plane origin.
  int scan_col;
  int scan_row;
  int plane_cols;
  int plane_rows;
  int plane_origin_col;
  int plane_origin_row;

  int error_count;
  int points_sent;
  int reports_matched;
  int register_writes;

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic gsod_pkg::value_t clamp_value(input longint v);
    if (v > longint'(gsod_pkg::VALUE_MAX)) return gsod_pkg::VALUE_MAX;
    if (v < longint'(gsod_pkg::VALUE_MIN)) return gsod_pkg::VALUE_MIN;
    return gsod_pkg::value_t'(v);
  endfunction

  // Predicts the outcome of one grid point and advances the suppression memory. Returns 1
  // when the point is reported, with the expected report in found.
  function automatic bit judge_point(input gsod_pkg::item_t p, output outlier_t found);
    int     dx;
    int     dy;
    longint value;
    longint magnitude;
    longint product;
    longint scaled_diff;
    found = '{default: '0};
    if (p.plane_start) tracked_valid = 1'b0;
    // Offsets are signed, so points behind the last report fall inside the window too.
    dx = int'(p.col) - int'(tracked_col);
    dy = int'(p.row) - int'(tracked_row);
    // Suppression comes first: a suppressed point is dropped whatever its data.
    if (tracked_valid && dx < int'(cur_skip_x) && dy < int'(cur_skip_y)) return 1'b0;
    if (p.observed == cur_value_bad || p.observed == cur_value_missing ||
        p.deviation == cur_stats_bad || p.deviation == cur_stats_missing ||
        p.mean_value == cur_stats_bad || p.mean_value == cur_stats_missing) return 1'b0;
    value = p.observed;
    // The magnitude of the most negative code does not fit, so it saturates.
    if (cur_use_abs && value < 0)
      value = (p.observed == gsod_pkg::VALUE_MIN) ? longint'(gsod_pkg::VALUE_MAX) : -value;
    // The magnitude of the most negative deviation, 2^31, is used exactly.
    magnitude = p.deviation;
    if (magnitude < 0) magnitude = -magnitude;
    // Q8.8 times Q16.16 gives Q24.24, so the difference is lifted by eight bits to match.
    product     = longint'(cur_sigma) * magnitude;
    scaled_diff = (value - longint'(p.mean_value)) * 256;
    if (!(scaled_diff > product || scaled_diff < -product)) return 1'b0;
    tracked_valid   = 1'b1;
    tracked_col     = p.col;
    tracked_row     = p.row;
    found.col       = p.col;
    found.row       = p.row;
    found.value     = gsod_pkg::value_t'(value);
    found.mean      = p.mean_value;
    found.deviation = p.deviation;
    return 1'b1;
  endfunction

  function automatic void apply_register(input logic [gsod_pkg::CFG_INDEX_BITS-1:0] index,
                                         input logic [gsod_pkg::CFG_DATA_BITS-1:0] data);
    case (index)
      gsod_pkg::REG_SIGMA:         cur_sigma         = data[gsod_pkg::SIGMA_BITS-1:0];
      gsod_pkg::REG_SKIP_X:        cur_skip_x        = data[gsod_pkg::COORD_BITS-1:0];
      gsod_pkg::REG_SKIP_Y:        cur_skip_y        = data[gsod_pkg::COORD_BITS-1:0];
      gsod_pkg::REG_USE_ABS:       cur_use_abs       = data[0];
      gsod_pkg::REG_VALUE_BAD:     cur_value_bad     = data;
      gsod_pkg::REG_VALUE_MISSING: cur_value_missing = data;
      gsod_pkg::REG_STATS_BAD:     cur_stats_bad     = data;
      gsod_pkg::REG_STATS_MISSING: cur_stats_missing = data;
      default: ;
    endcase
  endfunction

  function automatic gsod_pkg::item_t make_item(input int col, input int row,
                                                input gsod_pkg::value_t observed,
                                                input gsod_pkg::value_t mean_value,
                                                input gsod_pkg::value_t deviation,
                                                input bit plane_start);
    gsod_pkg::item_t p;
    p.col         = gsod_pkg::coord_t'(col);
    p.row         = gsod_pkg::coord_t'(row);
    p.observed    = observed;
    p.mean_value  = mean_value;
    p.deviation   = deviation;
    p.plane_start = plane_start;
    return p;
  endfunction

  // Offers one grid point word, idling beforehand at the sender's rate, and books the
  // predicted report once the word has been accepted.
  task automatic send_point(input gsod_pkg::item_t p);
    outlier_t found;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      samples_bus.valid <= 1'b0;
      @(negedge clk);
    end
    samples_bus.valid       <= 1'b1;
    samples_bus.col         <= p.col;
    samples_bus.row         <= p.row;
    samples_bus.observed    <= p.observed;
    samples_bus.mean_value  <= p.mean_value;
    samples_bus.deviation   <= p.deviation;
    samples_bus.plane_start <= p.plane_start;
    do @(posedge clk); while (!samples_bus.ready);
    if (judge_point(p, found)) pending_reports = {pending_reports, found};
    points_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    samples_bus.valid <= 1'b0;
  endtask

  // Holds the sender back until every predicted report has come out, then lets the last
  // words that report nothing clear the block.
  task automatic wait_for_reports();
    stop_sending();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [gsod_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [gsod_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_register(index, data);
    register_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic gsod_pkg::value_t pick_sentinel(input gsod_pkg::value_t fallback);
    case ($urandom_range(4))
      0:       return fallback;
      1:       return gsod_pkg::VALUE_MAX;
      2:       return gsod_pkg::VALUE_MIN;
      3:       return '0;
      default: return gsod_pkg::value_t'($urandom);
    endcase
  endfunction

  // Produces the next point of the random scan. Most points walk a raster over a small
  // plane, with values placed inside, on or beyond the sigma band of the current setting;
  // a few jump back, restart the plane early, hit a sentinel or are pure noise.
  function automatic gsod_pkg::item_t make_point();
    gsod_pkg::item_t p;
    longint          magnitude;
    longint          band;
    longint          offset;
    longint          obs;
    int              roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      p.col         = gsod_pkg::coord_t'($urandom);
      p.row         = gsod_pkg::coord_t'($urandom);
      p.observed    = gsod_pkg::value_t'($urandom);
      p.mean_value  = gsod_pkg::value_t'($urandom);
      p.deviation   = gsod_pkg::value_t'($urandom);
      p.plane_start = 1'($urandom_range(1));
      return p;
    end
    if ($urandom_range(19) == 0) begin
      scan_col = $urandom_range(plane_cols - 1);
      scan_row = $urandom_range(scan_row);
    end
    p.col         = gsod_pkg::coord_t'(plane_origin_col + scan_col);
    p.row         = gsod_pkg::coord_t'(plane_origin_row + scan_row);
    p.plane_start = (scan_col == 0 && scan_row == 0) || ($urandom_range(32) == 0);
    scan_col++;
    if (scan_col >= plane_cols) begin
      scan_col = 0;
      scan_row++;
    end
    if (scan_row >= plane_rows) begin
      scan_row         = 0;
      plane_origin_col = $urandom_range(4095);
      plane_origin_row = $urandom_range(4095);
    end

    if ($urandom_range(9) == 0) p.mean_value = gsod_pkg::value_t'($urandom);
    else p.mean_value = gsod_pkg::value_t'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
    if ($urandom_range(19) == 0) p.deviation = gsod_pkg::value_t'($urandom);
    else begin
      magnitude   = $urandom_range(0, 1 << 20);
      p.deviation = gsod_pkg::value_t'($urandom_range(1) ? -magnitude : magnitude);
    end

    magnitude = p.deviation;
    if (magnitude < 0) magnitude = -magnitude;
    band = (longint'(cur_sigma) * magnitude) >>> 8;
    case ($urandom_range(9))
      0, 1, 2, 3: offset = band * $urandom_range(0, 1000) / 1000;
      4, 5:       offset = band + $urandom_range(1);
      default:    offset = band + 1 + band * $urandom_range(0, 1000) / 1000
                           + $urandom_range(0, 1 << 16);
    endcase
    if ($urandom_range(1)) offset = -offset;
    obs = longint'(p.mean_value) + offset;
    // With magnitudes compared, a mirrored observation lands in the same place.
    if (cur_use_abs && $urandom_range(1)) obs = -obs;
    p.observed = clamp_value(obs);

    if ($urandom_range(99) < 6) begin
      case ($urandom_range(5))
        0:       p.observed   = cur_value_bad;
        1:       p.observed   = cur_value_missing;
        2:       p.mean_value = cur_stats_bad;
        3:       p.mean_value = cur_stats_missing;
        4:       p.deviation  = cur_stats_bad;
        default: p.deviation  = cur_stats_missing;
      endcase
    end
    return p;
  endfunction

  // The receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    results_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted report word is matched, field by field, against the oldest prediction.
  always @(posedge clk) begin : check_reports
    outlier_t want;
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (pending_reports.size() == 0) begin
        report_error($sformatf("report at column %0d row %0d with none expected",
                               results_bus.out_col, results_bus.out_row));
      end else begin
        want = pending_reports.pop_front();
        if (results_bus.out_col !== want.col)
          report_error($sformatf("out_col: expected %0d, got %0d", want.col, results_bus.out_col));
        if (results_bus.out_row !== want.row)
          report_error($sformatf("out_row: expected %0d, got %0d", want.row, results_bus.out_row));
        if (results_bus.out_value !== want.value)
          report_error($sformatf("out_value: expected %h, got %h",
                                 want.value, results_bus.out_value));
        if (results_bus.out_mean !== want.mean)
          report_error($sformatf("out_mean: expected %h, got %h",
                                 want.mean, results_bus.out_mean));
        if (results_bus.out_deviation !== want.deviation)
          report_error($sformatf("out_deviation: expected %h, got %h",
                                 want.deviation, results_bus.out_deviation));
        reports_matched++;
      end
    end
  end

  // Reset settings: a band of two deviations and skip distances of zero. Covers the band
  // edges on both sides, the exact boundary, extreme coordinates and a negative deviation.
  task automatic test_default_thresholds();
    send_point(make_item(0, 0, '0, '0, ONE, 1'b1));
    send_point(make_item(4095, 4095, 2 * ONE, '0, ONE, 1'b0));
    send_point(make_item(1, 2, 2 * ONE + 1, '0, ONE, 1'b0));
    send_point(make_item(4095, 0, -2 * ONE - 1, '0, ONE, 1'b0));
    send_point(make_item(0, 4095, gsod_pkg::VALUE_MAX, gsod_pkg::VALUE_MAX, ONE, 1'b0));
    send_point(make_item(5, 5, 3 * ONE, '0, -ONE, 1'b0));
  endtask

  // Each of the six sentinel comparisons on its own, with data that would otherwise report.
  task automatic test_sentinels();
    send_point(make_item(10, 1, gsod_pkg::BAD_RESET, '0, ONE, 1'b0));
    send_point(make_item(11, 1, gsod_pkg::MISSING_RESET, '0, ONE, 1'b0));
    send_point(make_item(12, 1, 100 * ONE, gsod_pkg::BAD_RESET, ONE, 1'b0));
    send_point(make_item(13, 1, 100 * ONE, gsod_pkg::MISSING_RESET, ONE, 1'b0));
    send_point(make_item(14, 1, 100 * ONE, '0, gsod_pkg::BAD_RESET, 1'b0));
    send_point(make_item(15, 1, 100 * ONE, '0, gsod_pkg::MISSING_RESET, 1'b0));
  endtask

  // Magnitude comparison, saturation of the most negative observation, the exact magnitude
  // of the most negative deviation, and the largest and smallest sigma.
  task automatic test_abs_and_extremes();
    wait_for_reports();
    write_register(gsod_pkg::REG_USE_ABS, 32'd1);
    write_register(gsod_pkg::REG_VALUE_BAD, 7 * ONE);
    write_register(gsod_pkg::REG_VALUE_MISSING, 32'h0BAD_0000);
    write_register(gsod_pkg::REG_STATS_BAD, 32'h7FFF_0000);
    write_register(gsod_pkg::REG_STATS_MISSING, 32'h1234_5678);
    send_point(make_item(100, 100, gsod_pkg::VALUE_MIN, '0, ONE, 1'b0));
    send_point(make_item(101, 100, -3 * ONE, '0, ONE, 1'b0));
    send_point(make_item(102, 100, -ONE, '0, ONE, 1'b0));
    wait_for_reports();
    write_register(gsod_pkg::REG_SIGMA, 32'(16'hFFFF));
    send_point(make_item(103, 100, gsod_pkg::VALUE_MAX, gsod_pkg::VALUE_MIN,
                         gsod_pkg::VALUE_MIN, 1'b0));
    wait_for_reports();
    write_register(gsod_pkg::REG_SIGMA, 32'd0);
    send_point(make_item(104, 100, ONE, ONE, gsod_pkg::VALUE_MIN, 1'b0));
    send_point(make_item(105, 100, 32'sd1, '0, gsod_pkg::VALUE_MIN, 1'b0));
    send_point(make_item(106, 100, gsod_pkg::VALUE_MIN, gsod_pkg::VALUE_MIN, '0, 1'b0));
    wait_for_reports();
    write_register(gsod_pkg::REG_USE_ABS, 32'd0);
    send_point(make_item(107, 100, gsod_pkg::VALUE_MIN, gsod_pkg::VALUE_MAX, '0, 1'b0));
  endtask

  // A window of four by four: a point ahead, a point behind and a sentinel point inside the
  // window are dropped; a point at exactly the column distance, one beyond in rows only,
  // and a fresh plane are reported.
  task automatic test_suppression();
    wait_for_reports();
    write_register(gsod_pkg::REG_SIGMA, 32'(gsod_pkg::SIGMA_RESET));
    write_register(gsod_pkg::REG_SKIP_X, 32'd4);
    write_register(gsod_pkg::REG_SKIP_Y, 32'd4);
    send_point(make_item(10, 10, 16 * ONE, '0, ONE, 1'b1));
    send_point(make_item(13, 13, 16 * ONE, '0, ONE, 1'b0));
    send_point(make_item(6, 7, 16 * ONE, '0, ONE, 1'b0));
    send_point(make_item(12, 12, 7 * ONE, '0, ONE, 1'b0));
    send_point(make_item(14, 10, 16 * ONE, '0, ONE, 1'b0));
    send_point(make_item(10, 20, 16 * ONE, '0, ONE, 1'b0));
    send_point(make_item(11, 21, 16 * ONE, '0, ONE, 1'b1));
  endtask

  // Writes past the register list must leave the configuration alone.
  task automatic test_register_index_beyond();
    wait_for_reports();
    write_register(gsod_pkg::CFG_INDEX_BITS'(REG_COUNT), 32'd0);
    write_register({gsod_pkg::CFG_INDEX_BITS{1'b1}}, 32'd0);
    send_point(make_item(2000, 2000, 16 * ONE, '0, ONE, 1'b1));
  endtask

  // Random raster scans, each segment under a fresh setting of every register and its own
  // idling profile. Early segments force the extremes of sigma and of the window.
  task automatic test_random_scan();
    int            seg;
    int            n;
    logic [15:0]   sigma_word;
    logic [11:0]   skip_word [2];
    for (seg = 0; seg < SCAN_SEGMENTS; seg++) begin
      wait_for_reports();
      case (seg % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      case ($urandom_range(3))
        0:       sigma_word = 16'($urandom_range(128, 1024));
        1:       sigma_word = 16'($urandom);
        2:       sigma_word = 16'($urandom_range(1, 255));
        default: sigma_word = 16'd256;
      endcase
      if (seg == 1) sigma_word = '0;
      if (seg == 2) sigma_word = '1;
      for (n = 0; n < 2; n++) begin
        case ($urandom_range(3))
          0:       skip_word[n] = '0;
          1, 2:    skip_word[n] = 12'($urandom_range(1, 8));
          default: skip_word[n] = 12'($urandom);
        endcase
        if (seg == 2) skip_word[n] = '1;
      end
      write_register(gsod_pkg::REG_SIGMA, 32'(sigma_word));
      write_register(gsod_pkg::REG_SKIP_X, 32'(skip_word[0]));
      write_register(gsod_pkg::REG_SKIP_Y, 32'(skip_word[1]));
      write_register(gsod_pkg::REG_USE_ABS, 32'($urandom_range(1)));
      write_register(gsod_pkg::REG_VALUE_BAD, pick_sentinel(gsod_pkg::BAD_RESET));
      write_register(gsod_pkg::REG_VALUE_MISSING, pick_sentinel(gsod_pkg::MISSING_RESET));
      write_register(gsod_pkg::REG_STATS_BAD, pick_sentinel(gsod_pkg::BAD_RESET));
      write_register(gsod_pkg::REG_STATS_MISSING, pick_sentinel(gsod_pkg::MISSING_RESET));
      scan_col         = 0;
      scan_row         = 0;
      plane_cols       = $urandom_range(4, 24);
      plane_rows       = $urandom_range(4, 16);
      plane_origin_col = $urandom_range(4095);
      plane_origin_row = $urandom_range(4095);
      for (n = 0; n < SEGMENT_POINTS; n++) begin
        send_point(make_point());
        // Once in the run, the sender holds off mid-stream until the block has emptied.
        if (seg == 3 && n == SEGMENT_POINTS / 2) wait_for_reports();
      end
    end
  endtask

  initial begin : run
    int waited;
    samples_bus.valid       = 1'b0;
    samples_bus.col         = '0;
    samples_bus.row         = '0;
    samples_bus.observed    = '0;
    samples_bus.mean_value  = '0;
    samples_bus.deviation   = '0;
    samples_bus.plane_start = 1'b0;
    results_bus.ready       = 1'b1;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = '0;
    cfg_bus.data            = '0;
    cur_sigma               = gsod_pkg::SIGMA_RESET;
    cur_skip_x              = '0;
    cur_skip_y              = '0;
    cur_use_abs             = 1'b0;
    cur_value_bad           = gsod_pkg::BAD_RESET;
    cur_value_missing       = gsod_pkg::MISSING_RESET;
    cur_stats_bad           = gsod_pkg::BAD_RESET;
    cur_stats_missing       = gsod_pkg::MISSING_RESET;
    tracked_valid           = 1'b0;
    tracked_col             = '0;
    tracked_row             = '0;
    send_idle_pct           = 25;
    recv_stall_pct          = 25;
    error_count             = 0;
    points_sent             = 0;
    reports_matched         = 0;
    register_writes         = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_default_thresholds();
    test_sentinels();
    test_abs_and_extremes();
    test_suppression();
    test_register_index_beyond();
    test_random_scan();

    // Let the last reports drain, then give the block time to show anything spurious.
    stop_sending();
    waited = 0;
    while (pending_reports.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0)
      report_error($sformatf("%0d predicted reports never arrived", pending_reports.size()));

    $display("Run covered %0d grid points and %0d register writes over %0d scan settings,",
             points_sent, register_writes, SCAN_SEGMENTS);
    $display("with %0d outlier reports compared and %0d mismatches.",
             reports_matched, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
